// ----- src/lzwc_pkg.sv -----
// Shared types and constants for the LZW byte compressor.
`default_nettype none
package lzwc_pkg;

  localparam int unsigned FIRST_FREE = 256;
  localparam int unsigned LIMIT_W    = 13;

  typedef struct packed {
    logic load;
    logic first;
    logic slot_inc;
    logic take_hit;
    logic emit;
    logic flush;
  } lzwc_cmd_t;

  typedef struct packed {
    logic match_valid;
    logic occupied;
    logic key_eq;
    logic out_free;
    logic last;
  } lzwc_stat_t;

endpackage
`default_nettype wire

// ----- src/lzwc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module lzwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/lzwc_ctrl.sv -----
// Controller state machine that sequences the dictionary probe for each word.
`default_nettype none
module lzwc_ctrl
  import lzwc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_is_last,
  output logic            in_ready,
  input  wire lzwc_stat_t stat,
  output lzwc_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HREAD = 6'b000010,
    S_DREAD = 6'b000100,
    S_CHECK = 6'b001000,
    S_MISS  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.match_valid) begin
            cmd.first = 1'b1;
            state_nxt = in_is_last ? S_FLUSH : S_IDLE;
          end else begin
            state_nxt = S_HREAD;
          end
        end
      end
      S_HREAD: state_nxt = S_DREAD;
      S_DREAD: state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.occupied && stat.key_eq) begin
          cmd.take_hit = 1'b1;
          state_nxt    = stat.last ? S_FLUSH : S_IDLE;
        end else if (stat.occupied) begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_HREAD;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.flush) |-> stat.out_free) else $error("push without room");
  a_probe_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HREAD) |=> (state_r == S_DREAD)) else $error("probe sequence broken");
  a_miss_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MISS && stat.out_free && !stat.last) |=> in_ready)
    else $error("miss did not return to idle");

endmodule
`default_nettype wire

// ----- src/lzwc_dpath.sv -----
// Datapath: match state, hashed slot table, code dictionary and output register.
`default_nettype none
module lzwc_dpath
  import lzwc_pkg::*;
#(
  parameter int unsigned DICT_SIZE = 4096,
  parameter int unsigned CODE_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [LIMIT_W-1:0]   cfg_data,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_is_last,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic      [CODE_BITS-1:0] out_code,
  output logic                      out_end_of_stream,
  input  wire lzwc_cmd_t            cmd,
  output lzwc_stat_t                stat
);

  localparam int unsigned AW   = $clog2(DICT_SIZE);
  localparam int unsigned NW   = CODE_BITS + 1;
  localparam int unsigned KW   = CODE_BITS + 8;
  localparam int unsigned DW   = KW + AW;
  localparam int unsigned CAP  = (DICT_SIZE < (1 << CODE_BITS)) ? DICT_SIZE
                                                                : (1 << CODE_BITS);

  logic [LIMIT_W-1:0]   cfg_r;
  logic [7:0]           byte_r;
  logic                 last_r;
  logic [CODE_BITS-1:0] match_r;
  logic                 mvalid_r;
  logic [NW-1:0]        nfc_r;
  logic [AW-1:0]        slot_r;
  logic                 out_valid_r;
  logic [CODE_BITS-1:0] out_code_r;
  logic                 out_eos_r;

  logic [CODE_BITS-1:0] h_rdata;
  logic [DW-1:0]        d_rdata;
  logic [NW-1:0]        lim;
  logic [AW:0]          h_raw;
  logic [AW-1:0]        hash;
  logic                 ins;

  always_comb begin
    if (32'(cfg_r) < CAP) begin
      lim = NW'(cfg_r);
    end else begin
      lim = NW'(CAP);
    end
  end

  always_comb begin
    h_raw = {1'b0, AW'(match_r) ^ (AW'(in_data_byte) << (AW - 8))};
    if (h_raw >= (AW + 1)'(DICT_SIZE)) begin
      hash = AW'(h_raw - (AW + 1)'(DICT_SIZE));
    end else begin
      hash = AW'(h_raw);
    end
  end

  assign ins = cmd.emit && (nfc_r < lim);

  lzwc_ram #(.WIDTH(CODE_BITS), .DEPTH(DICT_SIZE)) u_slot_ram (
    .clk   (clk),
    .we    (ins),
    .waddr (slot_r),
    .wdata (CODE_BITS'(nfc_r)),
    .raddr (slot_r),
    .rdata (h_rdata)
  );

  lzwc_ram #(.WIDTH(DW), .DEPTH(DICT_SIZE)) u_dict_ram (
    .clk   (clk),
    .we    (ins),
    .waddr (AW'(nfc_r)),
    .wdata ({match_r, byte_r, slot_r}),
    .raddr (AW'(h_rdata)),
    .rdata (d_rdata)
  );

  assign stat.match_valid = mvalid_r;
  assign stat.occupied    = (NW'(h_rdata) >= NW'(FIRST_FREE)) && (NW'(h_rdata) < nfc_r)
                            && (d_rdata[AW-1:0] == slot_r);
  assign stat.key_eq      = (d_rdata[DW-1:AW] == {match_r, byte_r});
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.last        = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= LIMIT_W'(4096);
      mvalid_r    <= 1'b0;
      match_r     <= '0;
      nfc_r       <= NW'(FIRST_FREE);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.emit || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        byte_r <= in_data_byte;
        last_r <= in_is_last;
        slot_r <= hash;
      end
      if (cmd.first) begin
        match_r  <= CODE_BITS'(in_data_byte);
        mvalid_r <= 1'b1;
      end
      if (cmd.slot_inc) begin
        slot_r <= (slot_r == AW'(DICT_SIZE - 1)) ? '0 : slot_r + 1'b1;
      end
      if (cmd.take_hit) begin
        match_r <= h_rdata;
      end
      if (cmd.emit) begin
        out_code_r  <= match_r;
        out_eos_r   <= 1'b0;
        match_r     <= CODE_BITS'(byte_r);
        if (ins) begin
          nfc_r <= nfc_r + 1'b1;
        end
      end
      if (cmd.flush) begin
        out_code_r  <= match_r;
        out_eos_r   <= 1'b1;
        match_r     <= '0;
        mvalid_r    <= 1'b0;
        nfc_r       <= NW'(FIRST_FREE);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code          = out_code_r;
  assign out_end_of_stream = out_eos_r;

  a_nfc_floor: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r >= NW'(FIRST_FREE)) else $error("free code below first free");
  a_flush_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (!mvalid_r && nfc_r == NW'(FIRST_FREE))) else $error("flush left a match");
  a_ins_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ins |-> (nfc_r < NW'(CAP))) else $error("insert past capacity");

endmodule
`default_nettype wire

// ----- src/lzw_byte_compressor_unit.sv -----
// Top level of the LZW byte compressor.
//
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/ready  | in_data_byte, in_is_last
//  out     | output    | out_valid/ready | out_code, out_end_of_stream
//  cfg     | input     | cfg_we          | cfg_data (code limit)
//
// A probed byte passes the slot read, dictionary read and check steps, and again
// for each extra slot probed; the slot RAM and dictionary RAM are read one after
// another. A miss or a flush adds a step each for the output register.
// Reset is synchronous; the RAMs need no clearing since slots are cross-checked.
// A stalled output holds the block at the miss or flush step.
`default_nettype none
module lzw_byte_compressor_unit
  import lzwc_pkg::*;
#(
  parameter int unsigned DICT_SIZE = 4096,
  parameter int unsigned CODE_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [LIMIT_W-1:0]   cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_is_last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [CODE_BITS-1:0] out_code,
  output logic                      out_end_of_stream
);

  lzwc_cmd_t  cmd;
  lzwc_stat_t stat;

  lzwc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lzwc_dpath #(.DICT_SIZE(DICT_SIZE), .CODE_BITS(CODE_BITS)) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_data_byte      (in_data_byte),
    .in_is_last        (in_is_last),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_code          (out_code),
    .out_end_of_stream (out_end_of_stream),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
`default_nettype wire
